// File: rtl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// Request kinds and result status codes of the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

endpackage

// File: rtl/gsa_ram.sv
// ----------------------------------------------------------------------------
// gsa_ram
// One write port, one read port, registered read data. A read of the address
// written at the same edge returns the new data.
// ----------------------------------------------------------------------------
module gsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/generational_slot_allocator.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Hands out pool slots as index plus generation handles; frees and checks them.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------
//  request  | in_valid_i / in_stall_o     | kind, handle index/generation,
//           |                             | payload word
//  result   | out_valid_o / out_stall_i   | status, index, generation,
//           |                             | payload word
//
// One request per cycle. A request is held in the request register while the
// memories are read, is decided there, and its result is then captured in the
// result register. Memory writes of one request are seen by the reads of the
// next through write-first bypass; the free-list link of the head is always
// prefetched. Reset clears the free list, the fill count, the active bits and
// the generation valid bits at once; no clearing pass. A stalled result holds
// the request register, which then stalls the request channel.
// ----------------------------------------------------------------------------
module generational_slot_allocator #(
  parameter int unsigned SLOTS        = 256,
  parameter int unsigned GEN_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [gsa_pkg::KIND_W-1:0]        kind_i,
  input  logic [$clog2(SLOTS)-1:0]          handle_index_i,
  input  logic [GEN_BITS-1:0]               handle_generation_i,
  input  logic [PAYLOAD_BITS-1:0]           payload_in_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output gsa_pkg::status_e                  status_o,
  output logic [$clog2(SLOTS)-1:0]          out_index_o,
  output logic [GEN_BITS-1:0]               out_generation_o,
  output logic [PAYLOAD_BITS-1:0]           payload_out_o
);

  import gsa_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  // handshake
  logic accept, advance, commit;

  // request register
  logic                    req_valid_q;
  logic [KIND_W-1:0]       req_kind_q;
  logic [IDX_W-1:0]        req_idx_q;
  logic [GEN_BITS-1:0]     req_gen_q;
  logic [PAYLOAD_BITS-1:0] req_pay_q;

  // pool state
  logic [IDX_W-1:0] free_head_q, free_head_d;
  logic [CNT_W-1:0] free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [SLOTS-1:0] active_q;
  logic [SLOTS-1:0] gen_vld_q;
  logic             gen_vld_rd_q;
  logic             act_rd_q;

  // memory ports
  logic                    gen_we, pay_we, nf_we;
  logic [IDX_W-1:0]        gen_wa, pay_wa, nf_wa, gen_ra, nf_ra;
  logic [GEN_BITS-1:0]     gen_wd, gen_rd;
  logic [IDX_W-1:0]        nf_wd, nf_rd;
  logic [PAYLOAD_BITS-1:0] pay_rd;
  logic [IDX_W-1:0]        alloc_slot_nxt;

  // decision
  logic                    in_range, hit, act_set, act_clr;
  logic [GEN_BITS-1:0]     gen_cur;
  status_e                 res_status;
  logic [IDX_W-1:0]        res_idx;
  logic [GEN_BITS-1:0]     res_gen;
  logic [PAYLOAD_BITS-1:0] res_pay;

  // result register
  logic                    out_valid_q;
  status_e                 status_q;
  logic [IDX_W-1:0]        out_idx_q;
  logic [GEN_BITS-1:0]     out_gen_q;
  logic [PAYLOAD_BITS-1:0] out_pay_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign commit     = req_valid_q && advance;
  assign in_stall_o = req_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (accept) begin
      req_valid_q <= 1'b1;
    end else if (commit) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_kind_q <= kind_i;
      req_idx_q  <= handle_index_i;
      req_gen_q  <= handle_generation_i;
      req_pay_q  <= payload_in_i;
    end
  end

  // decide the request in the request register
  assign gen_cur  = gen_vld_rd_q ? gen_rd : '0;
  assign in_range = {{(CNT_W-IDX_W){1'b0}}, req_idx_q} < used_q;
  assign hit      = in_range && act_rd_q && (gen_cur == req_gen_q);

  always_comb begin
    free_head_d = free_head_q;
    free_cnt_d  = free_cnt_q;
    used_d      = used_q;
    gen_we      = 1'b0;
    gen_wa      = req_idx_q;
    gen_wd      = gen_cur + GEN_BITS'(1);
    nf_we       = 1'b0;
    nf_wa       = req_idx_q;
    nf_wd       = free_head_q;
    pay_we      = 1'b0;
    pay_wa      = free_head_q;
    act_set     = 1'b0;
    act_clr     = 1'b0;
    res_status  = ST_INVALID;
    res_idx     = req_idx_q;
    res_gen     = '0;
    res_pay     = '0;
    case (req_kind_q)
      KIND_ALLOC: begin
        if (free_cnt_q != '0) begin
          // pop the free-list head
          pay_we      = commit;
          pay_wa      = free_head_q;
          free_head_d = commit ? nf_rd : free_head_q;
          free_cnt_d  = commit ? free_cnt_q - CNT_W'(1) : free_cnt_q;
        end else if (used_q < CNT_W'(SLOTS)) begin
          // take the next never-used slot
          pay_we = commit;
          pay_wa = used_q[IDX_W-1:0];
          used_d = commit ? used_q + CNT_W'(1) : used_q;
        end
        if ((free_cnt_q != '0) || (used_q < CNT_W'(SLOTS))) begin
          act_set    = commit;
          res_status = ST_OK;
          res_idx    = pay_wa;
          res_gen    = gen_cur;
        end else begin
          res_status = ST_FULL;
        end
      end
      KIND_FREE: begin
        if (hit) begin
          act_clr     = commit;
          gen_we      = commit;
          nf_we       = commit;
          free_head_d = commit ? req_idx_q : free_head_q;
          free_cnt_d  = commit ? free_cnt_q + CNT_W'(1) : free_cnt_q;
          res_status  = ST_OK;
        end
      end
      KIND_QUERY: begin
        if (hit) begin
          res_status = ST_OK;
          res_gen    = gen_cur;
          res_pay    = pay_rd;
        end
      end
      default: begin
      end
    endcase
  end

  // read addresses follow the state that holds after this edge
  assign alloc_slot_nxt = (free_cnt_d != '0) ? free_head_d : used_d[IDX_W-1:0];
  assign gen_ra = (kind_i == KIND_ALLOC) ? alloc_slot_nxt : handle_index_i;
  assign nf_ra  = free_head_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= '0;
      free_cnt_q   <= '0;
      used_q       <= '0;
      active_q     <= '0;
      gen_vld_q    <= '0;
      gen_vld_rd_q <= 1'b0;
      act_rd_q     <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      used_q      <= used_d;
      if (act_set) begin
        active_q[pay_wa] <= 1'b1;
      end
      if (act_clr) begin
        active_q[req_idx_q] <= 1'b0;
      end
      if (gen_we) begin
        gen_vld_q[gen_wa] <= 1'b1;
      end
      if (accept) begin
        gen_vld_rd_q <= (gen_we && (gen_wa == gen_ra)) || gen_vld_q[gen_ra];
        // capture the active bit as it stands after this edge
        if (act_set && (pay_wa == handle_index_i)) begin
          act_rd_q <= 1'b1;
        end else if (act_clr && (req_idx_q == handle_index_i)) begin
          act_rd_q <= 1'b0;
        end else begin
          act_rd_q <= active_q[handle_index_i];
        end
      end
    end
  end

  gsa_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (SLOTS)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_wa),
    .wdata_i (gen_wd),
    .re_i    (accept),
    .raddr_i (gen_ra),
    .rdata_o (gen_rd)
  );

  gsa_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SLOTS)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_wa),
    .wdata_i (req_pay_q),
    .re_i    (accept),
    .raddr_i (handle_index_i),
    .rdata_o (pay_rd)
  );

  gsa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_nf_ram (
    .clk_i   (clk_i),
    .we_i    (nf_we),
    .waddr_i (nf_wa),
    .wdata_i (nf_wd),
    .re_i    (1'b1),
    .raddr_i (nf_ra),
    .rdata_o (nf_rd)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q  <= res_status;
      out_idx_q <= res_idx;
      out_gen_q <= res_gen;
      out_pay_q <= res_pay;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_index_o      = out_idx_q;
  assign out_generation_o = out_gen_q;
  assign payload_out_o    = out_pay_q;

  // the free list never holds more slots than were ever handed out
  a_free_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= used_q)
    else $error("free list longer than used slots");

  // a successful free pushes the freed slot as the new head
  a_free_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (req_kind_q == KIND_FREE) && hit
    |=> (free_head_q == $past(req_idx_q)) && (free_cnt_q == $past(free_cnt_q) + CNT_W'(1)))
    else $error("free did not push the slot");

  // a successful allocate leaves its slot active
  a_alloc_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (req_kind_q == KIND_ALLOC) && (res_status == ST_OK)
    |=> active_q[$past(res_idx)])
    else $error("allocated slot not active");

  // a stalled result keeps the request register from advancing
  a_hold_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && out_valid_q && out_stall_i |=> req_valid_q && $stable(req_idx_q))
    else $error("request register moved under stall");

endmodule

// File: tb/sv/gsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_checker
// Watches both channels of the slot allocator, keeps its own copy of the pool
// (generations, active bits, free-list links, payloads) and compares every
// result with the one predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module gsa_checker #(
  parameter int unsigned SLOTS        = 256,
  parameter int unsigned GEN_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              req_valid_i,
  input  logic                              req_stall_i,
  input  logic [gsa_pkg::KIND_W-1:0]        req_kind_i,
  input  logic [$clog2(SLOTS)-1:0]          req_index_i,
  input  logic [GEN_BITS-1:0]               req_generation_i,
  input  logic [PAYLOAD_BITS-1:0]           req_payload_i,

  input  logic                              rsp_valid_i,
  input  logic                              rsp_stall_i,
  input  gsa_pkg::status_e                  rsp_status_i,
  input  logic [$clog2(SLOTS)-1:0]          rsp_index_i,
  input  logic [GEN_BITS-1:0]               rsp_generation_i,
  input  logic [PAYLOAD_BITS-1:0]           rsp_payload_i,

  output int                                pending_o,
  output int                                fail_count_o
);

  import gsa_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);

  typedef struct packed {
    status_e                  status;
    logic [IDX_W-1:0]         index;
    logic [GEN_BITS-1:0]      generation;
    logic [PAYLOAD_BITS-1:0]  payload;
  } slot_result_t;

  // Shadow of the pool
  logic [GEN_BITS-1:0]      gen_mem  [SLOTS];
  logic                     live_bit [SLOTS];
  logic [IDX_W-1:0]         next_link[SLOTS];
  logic [PAYLOAD_BITS-1:0]  word_mem [SLOTS];
  logic [IDX_W-1:0]         head_slot;
  int                       list_len;
  int                       fill_count;

  slot_result_t expected_results[$];
  int           failures;

  function automatic slot_result_t predict_slot_result(
    input logic [KIND_W-1:0]        kind,
    input logic [IDX_W-1:0]         idx,
    input logic [GEN_BITS-1:0]      gen,
    input logic [PAYLOAD_BITS-1:0]  word
  );
    slot_result_t     r;
    logic [IDX_W-1:0] s;
    logic             hit;
    r.status     = ST_INVALID;
    r.index      = idx;
    r.generation = '0;
    r.payload    = '0;
    hit = (int'(idx) < fill_count) && live_bit[idx] && (gen_mem[idx] == gen);
    case (kind)
      KIND_ALLOC: begin
        if (list_len != 0 || fill_count < SLOTS) begin
          if (list_len != 0) begin
            s         = head_slot;
            head_slot = next_link[s];
            list_len--;
          end else begin
            s = IDX_W'(fill_count);
            fill_count++;
          end
          word_mem[s]  = word;
          live_bit[s]  = 1'b1;
          r.status     = ST_OK;
          r.index      = s;
          r.generation = gen_mem[s];
        end else begin
          r.status = ST_FULL;
        end
      end
      KIND_FREE: begin
        if (hit) begin
          live_bit[idx]  = 1'b0;
          gen_mem[idx]   = gen_mem[idx] + 1'b1;
          next_link[idx] = head_slot;
          head_slot      = idx;
          list_len++;
          r.status = ST_OK;
        end
      end
      KIND_QUERY: begin
        if (hit) begin
          r.status     = ST_OK;
          r.generation = gen_mem[idx];
          r.payload    = word_mem[idx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic log_mismatch(input string what, input slot_result_t want,
                              input slot_result_t got);
    failures++;
    if (failures <= 10) begin
      $display("gsa_checker: %s: expected st %0d idx %0d gen %h pay %h", what,
               want.status, want.index, want.generation, want.payload);
      $display("gsa_checker:   got st %0d idx %0d gen %h pay %h",
               got.status, got.index, got.generation, got.payload);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t want;
    slot_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        gen_mem[i]   = '0;
        live_bit[i]  = 1'b0;
        next_link[i] = '0;
        word_mem[i]  = '0;
      end
      head_slot  = '0;
      list_len   = 0;
      fill_count = 0;
      failures   = 0;
      expected_results.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        got = '{rsp_status_i, rsp_index_i, rsp_generation_i, rsp_payload_i};
        if (expected_results.size() == 0) begin
          log_mismatch("result with no request outstanding", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) log_mismatch("result mismatch", want, got);
        end
      end
      if (req_valid_i && !req_stall_i)
        expected_results.insert(expected_results.size(),
                                predict_slot_result(req_kind_i, req_index_i,
                                                    req_generation_i, req_payload_i));
      pending_o    <= expected_results.size();
      fail_count_o <= failures;
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the generational slot allocator: a short run of allocate/free
// cycles on one slot, a handful of directed requests, then random segments
// that fill and drain the pool with bursty requests and a receiver that stalls
// in patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import gsa_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] generation;
  } slot_handle_t;

  typedef enum int { MIX_FILL, MIX_MIXED, MIX_DRAIN } mix_e;
  typedef enum int { STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG } stall_e;

  logic              clk_i               = 1'b0;
  logic              rst_ni              = 1'b0;
  logic              in_valid_i          = 1'b0;
  logic              in_stall_o;
  logic [KIND_W-1:0] kind_i              = KIND_ALLOC;
  logic [7:0]        handle_index_i      = '0;
  logic [15:0]       handle_generation_i = '0;
  logic [31:0]       payload_in_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i         = 1'b0;
  status_e           status_o;
  logic [7:0]        out_index_o;
  logic [15:0]       out_generation_o;
  logic [31:0]       payload_out_o;

  int results_pending;
  int mismatch_count;

  generational_slot_allocator dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .kind_i              (kind_i),
    .handle_index_i      (handle_index_i),
    .handle_generation_i (handle_generation_i),
    .payload_in_i        (payload_in_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .out_index_o         (out_index_o),
    .out_generation_o    (out_generation_o),
    .payload_out_o       (payload_out_o)
  );

  gsa_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (in_valid_i),
    .req_stall_i      (in_stall_o),
    .req_kind_i       (kind_i),
    .req_index_i      (handle_index_i),
    .req_generation_i (handle_generation_i),
    .req_payload_i    (payload_in_i),
    .rsp_valid_i      (out_valid_o),
    .rsp_stall_i      (out_stall_i),
    .rsp_status_i     (status_o),
    .rsp_index_i      (out_index_o),
    .rsp_generation_i (out_generation_o),
    .rsp_payload_i    (payload_out_o),
    .pending_o        (results_pending),
    .fail_count_o     (mismatch_count)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Receiver stall patterns
  stall_e stall_mode = STALL_NONE;
  int     stall_left = 0;
  int     stall_tick = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall_i <= (stall_tick % 7) < 3;
      default:        out_stall_i <= ($urandom_range(0, 15) == 0) ? ~out_stall_i : out_stall_i;
    endcase
  end

  // Handles learned from results, used to build well-formed request streams
  logic [KIND_W-1:0] sent_kinds[$];
  slot_handle_t      live_handles[$];
  slot_handle_t      stale_handles[$];
  bit                track_en   = 1'b0;
  int                burst_left = 0;

  always @(posedge clk_i) begin
    logic [KIND_W-1:0] k;
    if (rst_ni && out_valid_o && !out_stall_i && sent_kinds.size() != 0) begin
      k = sent_kinds.pop_front();
      if (track_en && k == KIND_ALLOC && status_o == ST_OK)
        live_handles.insert(live_handles.size(),
                            slot_handle_t'{out_index_o, out_generation_o});
    end
  end

  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [7:0] idx,
                          input logic [15:0] gen, input logic [31:0] word);
    bit taken;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i          <= 1'b1;
    kind_i              <= kind;
    handle_index_i      <= idx;
    handle_generation_i <= gen;
    payload_in_i        <= word;
    // hold until the request is taken; stall is settled by the falling edge
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sent_kinds.insert(sent_kinds.size(), kind);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (results_pending != 0);
    @(posedge clk_i);
  endtask

  task automatic issue_random(input mix_e mix);
    int           r;
    int           alloc_pct;
    int           free_pct;
    int           j;
    slot_handle_t h;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin alloc_pct = 65; free_pct = 10; end
      MIX_DRAIN: begin alloc_pct = 15; free_pct = 55; end
      default:   begin alloc_pct = 35; free_pct = 30; end
    endcase
    h = '{8'($urandom), 16'($urandom)};
    if (r < alloc_pct) begin
      send_req(KIND_ALLOC, 8'($urandom), 16'($urandom), $urandom);
    end else if (r < alloc_pct + free_pct) begin
      if (live_handles.size() != 0 && $urandom_range(0, 99) < 85) begin
        j = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[j];
        live_handles.delete(j);
        stale_handles.insert(stale_handles.size(), h);
        if (stale_handles.size() > 64) void'(stale_handles.pop_front());
      end else if (stale_handles.size() != 0 && $urandom_range(0, 1) == 0) begin
        h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
      end
      send_req(KIND_FREE, h.index, h.generation, $urandom);
    end else if (r < 93) begin
      j = $urandom_range(0, 9);
      if (live_handles.size() != 0 && j < 7) begin
        h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        // off-by-one generation on a live slot
        if (j == 6) h.generation = h.generation + 1'b1;
      end else if (stale_handles.size() != 0 && j < 9) begin
        h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
      end
      send_req(KIND_QUERY, h.index, h.generation, $urandom);
    end else begin
      send_req(KIND_W'($urandom_range(0, 3)), h.index, h.generation, $urandom);
    end
  endtask

  initial begin
    int   items;
    int   seg;
    int   len;
    int   guard;
    mix_e mix;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Cycle slot 0 through its first few generations
    for (int g = 0; g < 8; g++) begin
      send_req(KIND_ALLOC, 8'd0, 16'd0, $urandom);
      send_req(KIND_FREE, 8'd0, g[15:0], 32'd0);
    end
    wait_drained();

    send_req(KIND_QUERY, 8'd0, 16'd0, 32'd0);           // freed slot
    send_req(KIND_ALLOC, 8'hff, 16'hffff, 32'h0000_0000);
    send_req(KIND_QUERY, 8'd0, 16'd8, 32'hffff_ffff);   // current generation
    send_req(KIND_QUERY, 8'd0, 16'd1, 32'd0);
    send_req(KIND_ALLOC, 8'd0, 16'd0, 32'hffff_ffff);
    send_req(KIND_QUERY, 8'd1, 16'd0, 32'd0);
    send_req(KIND_QUERY, 8'hff, 16'hffff, 32'd0);       // beyond the filled part
    send_req(KIND_FREE, 8'd1, 16'hffff, 32'd0);
    send_req(KIND_FREE, 8'd1, 16'd0, 32'd0);
    send_req(KIND_FREE, 8'd1, 16'd0, 32'd0);            // double free
    send_req(KIND_QUERY, 8'd1, 16'd1, 32'd0);
    send_req(KIND_UNUSED, 8'haa, 16'h5555, 32'h1234_5678);
    send_req(KIND_UNUSED, 8'h00, 16'h0000, 32'hffff_ffff);
    send_req(KIND_ALLOC, 8'h55, 16'haaaa, 32'hdead_beef); // reuse of slot 1
    send_req(KIND_QUERY, 8'd1, 16'd1, 32'd0);
    send_req(KIND_FREE, 8'd200, 16'd0, 32'd0);          // never used
    send_req(KIND_ALLOC, 8'd0, 16'd0, 32'ha5a5_a5a5);
    send_req(KIND_QUERY, 8'd2, 16'd0, 32'd0);
    wait_drained();

    track_en = 1'b1;
    items    = 0;
    seg      = 0;
    while (items < 1950) begin
      case (seg % 4)
        0, 1:    mix = MIX_FILL;
        2:       mix = MIX_MIXED;
        default: mix = MIX_DRAIN;
      endcase
      len = $urandom_range(200, 320);
      repeat (len) issue_random(mix);
      items += len;
      seg++;
      if (seg % 3 == 0) wait_drained();
    end

    in_valid_i <= 1'b0;
    guard = 0;
    while (results_pending != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
